/* rtl/bb3_pkg.sv */
// Shared types, constants and helper functions for the 3x3 edge-aware box blur.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package bb3_pkg;

    // Frame limits and the widths that follow from them.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WID_W      = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W      = $clog2(MAX_HEIGHT + 1);

    // Register field widths are fixed by the register map.
    localparam int FW_W = 11;
    localparam int FH_W = 13;
    localparam logic [FW_W-1:0] RESET_WIDTH  = 11'd640;
    localparam logic [FH_W-1:0] RESET_HEIGHT = 13'd480;

    // Configuration port: two 32-bit registers, one word apart.
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 1;
    localparam int APB_AW    = REG_IDX_W + 2;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;
    localparam t_reg_idx REG_FRAME_WIDTH  = 1'b0;
    localparam t_reg_idx REG_FRAME_HEIGHT = 1'b1;

    // Pixel and arithmetic widths.
    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam int SUM_W   = 12;
    localparam int X_W     = SUM_W + 1;
    localparam int RECIP_W = 15;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = X_W + RECIP_W;

    // Output queue depth.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef logic [COL_W-1:0] t_col;
    typedef logic [ROW_W-1:0] t_row;
    typedef logic [WID_W-1:0] t_wid;
    typedef logic [HGT_W-1:0] t_hgt;
    typedef logic [X_W-1:0]   t_x;

    // Pixel: index 2 is red, 1 is green, 0 is blue.
    typedef logic [2:0][CH_W-1:0]  t_pix;
    typedef logic [2:0][SUM_W-1:0] t_sums;

    // One line store entry: the pixel two rows up and the one a row up.
    typedef struct packed {
        t_pix above1;
        t_pix above2;
    } t_line_word;

    // Divisor selection for a neighborhood of 4, 6 or 9 pixels.
    typedef enum logic [1:0] {
        DIV_4 = 2'b00,
        DIV_6 = 2'b01,
        DIV_9 = 2'b10
    } t_div;

    // Per-item control carried down the pipeline.
    typedef struct packed {
        logic v0;      // result centered on window column 1
        logic v1;      // result centered on window column 2 (right edge)
        logic eof;     // right-edge result is the frame's last pixel
        logic use_c0;  // column-1 result includes window column 0
        logic use_r0;  // window row 0 is inside the frame
        logic use_r2;  // window row 2 is inside the frame
    } t_ctl;

    // One output word as it waits in the queue.
    typedef struct packed {
        logic eof;
        logic last;
        t_pix pix;
    } t_result;

    // Reciprocal scaled by 2^FRAC_W, rounded up; exact for sums below 2^15.
    function automatic logic [RECIP_W-1:0] recip(input t_div d);
        logic [RECIP_W-1:0] m;
        case (d)
            DIV_6:   m = 15'd10923;
            DIV_9:   m = 15'd7282;
            default: m = 15'd16384;
        endcase
        return m;
    endfunction

    // Half the divisor, for rounding half up.
    function automatic logic [2:0] half(input t_div d);
        logic [2:0] h;
        case (d)
            DIV_6:   h = 3'd3;
            DIV_9:   h = 3'd4;
            default: h = 3'd2;
        endcase
        return h;
    endfunction

endpackage

/* rtl/box_blur_3x3_edge_aware_unit.sv */
// 3x3 edge-aware box blur of an RGB pixel stream: top level.
// Holds the configuration port, the raster counters and the pipeline control;
// instantiates bb3_line_store, bb3_window, bb3_divide and bb3_out_queue; uses bb3_pkg.
//
// Usage:
//   Pixels enter in raster order on the s_axis channel (tuser = 0); after the last
//   pixel of a frame, frame_width drain words (tuser = 1) flush the bottom row.
//   Results leave on m_axis in raster order, delayed by one row and one pixel;
//   tlast marks the last result caused by one input word, tuser marks the
//   bottom-right pixel. A word at row 0 produces nothing; the last word of each
//   row and the last drain word produce two results.
//   Pipeline: accept, line store read, window, sum, product, then the output queue.
//   Throughput: one input word per cycle while the output queue has room, as the
//   line store RAM is read and written once per cycle. The result stage pushes one
//   word per cycle, so a word with two results holds the input until its second
//   result is pushed. The user must write frame_width and frame_height over APB
//   only while the block is idle; the block itself does not enforce this.
//   Reset: counters, window and queue clear, sizes return to 640 by 480; the
//   line store is not cleared, as no result ever depends on an unwritten entry.
//   Stall: a 4-word queue absorbs output stalls; tready drops when full on a push.
`timescale 1ns / 1ps

module box_blur_3x3_edge_aware_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [23:0]                   s_axis_tdata,  // red_in, green_in, blue_in
    input  logic                          s_axis_tuser,  // mode
    // Output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [23:0]                   m_axis_tdata,  // red_out, green_out, blue_out
    output logic                          m_axis_tlast,
    output logic                          m_axis_tuser,  // end_of_frame
    // Configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bb3_pkg::APB_AW-1:0]    paddr,
    input  logic [bb3_pkg::APB_DW-1:0]    pwdata,
    output logic [bb3_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    // Configuration registers
    logic [bb3_pkg::FW_W-1:0] r_frame_width;
    logic [bb3_pkg::FH_W-1:0] r_frame_height;
    bb3_pkg::t_reg_idx        w_reg_idx;
    logic                     w_cfg_wr;

    // Clamped sizes and positions
    bb3_pkg::t_wid w_wid;
    bb3_pkg::t_hgt w_hgt;
    bb3_pkg::t_col w_lcol;
    bb3_pkg::t_row w_lrow;
    bb3_pkg::t_col w_c;
    bb3_pkg::t_row w_r;
    bb3_pkg::t_wid w_rem;
    bb3_pkg::t_col w_k;

    // Raster counters
    bb3_pkg::t_col r_col;
    bb3_pkg::t_row r_row;
    bb3_pkg::t_wid r_drain;
    bb3_pkg::t_col n_col;
    bb3_pkg::t_row n_row;
    bb3_pkg::t_wid n_drain;

    // Accept stage decode
    logic          w_accept;
    logic          w_adv;
    bb3_pkg::t_ctl w_ctl;
    bb3_pkg::t_col w_addr;
    logic          w_pixel;
    logic          w_shift;
    bb3_pkg::t_pix w_px;

    // Line store read stage
    logic          r_b_valid;
    bb3_pkg::t_ctl r_b_ctl;
    logic          r_b_pixel;
    logic          r_b_shift;
    bb3_pkg::t_pix r_b_px;
    bb3_pkg::t_col r_b_addr;
    bb3_pkg::t_line_word w_rd_data;
    bb3_pkg::t_line_word w_wr_data;
    logic          w_wr_en;
    logic          w_win_shift;

    // Window, sum and product stages
    logic          r_c_valid;
    bb3_pkg::t_ctl r_c_ctl;
    logic          r_d_valid;
    bb3_pkg::t_ctl r_d_ctl;
    logic          r_e_valid;
    bb3_pkg::t_ctl r_e_ctl;
    logic          r_e_sent0;
    bb3_pkg::t_sums w_sum0;
    bb3_pkg::t_sums w_sum1;
    bb3_pkg::t_div  w_div0;
    bb3_pkg::t_div  w_div1;
    bb3_pkg::t_pix  w_q0;
    bb3_pkg::t_pix  w_q1;

    // Result hand-off
    logic             w_p0;
    logic             w_p1;
    logic             w_push;
    logic             w_room;
    bb3_pkg::t_result w_push_data;
    bb3_pkg::t_result w_head;
    logic             w_pop;

    // ---------------------------------------------------------------------
    // APB register file
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[bb3_pkg::APB_AW-1:2];
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bb3_pkg::RESET_WIDTH;
            r_frame_height <= bb3_pkg::RESET_HEIGHT;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                bb3_pkg::REG_FRAME_WIDTH:  r_frame_width  <= pwdata[bb3_pkg::FW_W-1:0];
                bb3_pkg::REG_FRAME_HEIGHT: r_frame_height <= pwdata[bb3_pkg::FH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            bb3_pkg::REG_FRAME_WIDTH:  prdata = bb3_pkg::APB_DW'(r_frame_width);
            bb3_pkg::REG_FRAME_HEIGHT: prdata = bb3_pkg::APB_DW'(r_frame_height);
            default:                   prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Frame size clamped to the supported range
    always_comb begin
        if (32'(r_frame_width) < 2) begin
            w_wid = bb3_pkg::t_wid'(2);
        end else if (32'(r_frame_width) > bb3_pkg::MAX_WIDTH) begin
            w_wid = bb3_pkg::t_wid'(bb3_pkg::MAX_WIDTH);
        end else begin
            w_wid = bb3_pkg::t_wid'(r_frame_width);
        end
        if (32'(r_frame_height) < 2) begin
            w_hgt = bb3_pkg::t_hgt'(2);
        end else if (32'(r_frame_height) > bb3_pkg::MAX_HEIGHT) begin
            w_hgt = bb3_pkg::t_hgt'(bb3_pkg::MAX_HEIGHT);
        end else begin
            w_hgt = bb3_pkg::t_hgt'(r_frame_height);
        end
    end

    assign w_lcol = bb3_pkg::t_col'(w_wid - bb3_pkg::t_wid'(1));
    assign w_lrow = bb3_pkg::t_row'(w_hgt - bb3_pkg::t_hgt'(1));

    // Positions past the current size count as the last column or row.
    assign w_c   = (r_col < w_lcol) ? r_col : w_lcol;
    assign w_r   = (r_row < w_lrow) ? r_row : w_lrow;
    assign w_rem = (r_drain > w_wid) ? w_wid : r_drain;
    assign w_k   = bb3_pkg::t_col'(w_wid - w_rem);

    // Input unpacking: red sits in the lowest byte of tdata.
    assign w_px[2] = s_axis_tdata[7:0];
    assign w_px[1] = s_axis_tdata[15:8];
    assign w_px[0] = s_axis_tdata[23:16];

    // ---------------------------------------------------------------------
    // Accept stage: item decode and counter update
    assign s_axis_tready = w_adv;
    assign w_accept      = s_axis_tvalid && w_adv;

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_drain = r_drain;
        w_ctl   = '0;
        w_addr  = w_c;
        w_pixel = 1'b0;
        w_shift = 1'b0;
        if (s_axis_tuser) begin
            // Drain word: replay the stored last rows with no row below.
            w_addr = w_k;
            if (r_drain != '0) begin
                w_shift      = 1'b1;
                w_ctl.v0     = (w_k != '0);
                w_ctl.v1     = (w_k == w_lcol);
                w_ctl.eof    = 1'b1;
                w_ctl.use_c0 = (32'(w_k) >= 2);
                w_ctl.use_r0 = 1'b1;
                w_ctl.use_r2 = 1'b0;
                n_drain      = w_rem - bb3_pkg::t_wid'(1);
            end
        end else begin
            // Pixel word: results for the row above, one pixel behind.
            w_pixel      = 1'b1;
            w_shift      = 1'b1;
            w_ctl.v0     = (w_r != '0) && (w_c != '0);
            w_ctl.v1     = (w_r != '0) && (w_c == w_lcol);
            w_ctl.eof    = 1'b0;
            w_ctl.use_c0 = (32'(w_c) >= 2);
            w_ctl.use_r0 = (32'(w_r) >= 2);
            w_ctl.use_r2 = 1'b1;
            n_drain      = '0;
            if (w_c == w_lcol) begin
                n_col = '0;
                if (w_r == w_lrow) begin
                    n_row   = '0;
                    n_drain = w_wid;
                end else begin
                    n_row = w_r + bb3_pkg::t_row'(1);
                end
            end else begin
                n_col = w_c + bb3_pkg::t_col'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_drain <= '0;
        end else if (w_accept) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_drain <= n_drain;
        end
    end

    // ---------------------------------------------------------------------
    // Pipeline valid bits; every stage moves together on w_adv.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else if (w_adv) begin
            r_b_valid <= w_accept;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_ctl   <= w_accept ? w_ctl : '0;
            r_b_pixel <= w_pixel;
            r_b_shift <= w_shift;
            r_b_px    <= w_px;
            r_b_addr  <= w_addr;
            r_c_ctl   <= r_b_ctl;
            r_d_ctl   <= r_c_ctl;
            r_e_ctl   <= r_d_ctl;
        end
    end

    // ---------------------------------------------------------------------
    // Line store: read at accept; the read stage writes back the shifted column.
    assign w_wr_en          = w_adv && r_b_valid && r_b_pixel;
    assign w_wr_data.above2 = w_rd_data.above1;
    assign w_wr_data.above1 = r_b_px;
    assign w_win_shift      = w_adv && r_b_valid && r_b_shift;

    bb3_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_b_addr),
        .i_wr_data (w_wr_data)
    );

    bb3_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (w_win_shift),
        .i_top   (w_rd_data.above2),
        .i_mid   (w_rd_data.above1),
        .i_bot   (r_b_pixel ? r_b_px : '0),
        .i_adv   (w_adv),
        .i_ctl   (r_c_ctl),
        .o_sum0  (w_sum0),
        .o_sum1  (w_sum1),
        .o_div0  (w_div0),
        .o_div1  (w_div1)
    );

    bb3_divide u_divide0 (
        .i_clk (i_clk),
        .i_adv (w_adv),
        .i_sum (w_sum0),
        .i_div (w_div0),
        .o_pix (w_q0)
    );

    bb3_divide u_divide1 (
        .i_clk (i_clk),
        .i_adv (w_adv),
        .i_sum (w_sum1),
        .i_div (w_div1),
        .o_pix (w_q1)
    );

    // ---------------------------------------------------------------------
    // Result stage: up to two results per item, one pushed per cycle when there is room.
    assign w_p0   = r_e_valid && r_e_ctl.v0 && !r_e_sent0;
    assign w_p1   = r_e_valid && r_e_ctl.v1;
    assign w_push = w_room && (w_p0 || w_p1);
    assign w_adv  = !(w_p0 || w_p1) || (w_room && !(w_p0 && w_p1));

    always_comb begin
        if (w_p0) begin
            w_push_data.eof  = 1'b0;
            w_push_data.last = !r_e_ctl.v1;
            w_push_data.pix  = w_q0;
        end else begin
            w_push_data.eof  = r_e_ctl.eof;
            w_push_data.last = 1'b1;
            w_push_data.pix  = w_q1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_sent0 <= 1'b0;
        end else if (w_adv) begin
            r_e_sent0 <= 1'b0;
        end else if (w_push && w_p0) begin
            r_e_sent0 <= 1'b1;
        end
    end

    bb3_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_room  (w_room),
        .o_valid (m_axis_tvalid),
        .o_data  (w_head),
        .i_pop   (w_pop)
    );

    // Output packing: red in the lowest byte.
    assign w_pop        = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata = {w_head.pix[0], w_head.pix[1], w_head.pix[2]};
    assign m_axis_tlast = w_head.last;
    assign m_axis_tuser = w_head.eof;

endmodule

/* rtl/bb3_line_store.sv */
// Two-row line store: one synchronous RAM holding both previous rows per column.
// Uses bb3_pkg for widths and the entry layout.
`timescale 1ns / 1ps

module bb3_line_store (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  bb3_pkg::t_col       i_rd_addr,
    output bb3_pkg::t_line_word o_rd_data,
    input  logic                i_wr_en,
    input  bb3_pkg::t_col       i_wr_addr,
    input  bb3_pkg::t_line_word i_wr_data
);

    bb3_pkg::t_line_word r_mem [bb3_pkg::MAX_WIDTH];
    bb3_pkg::t_line_word r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read; a write to the same entry in the same cycle is forwarded.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/bb3_window.sv */
// 3x3 pixel window and the neighborhood sums for the two possible results.
// Uses bb3_pkg for pixel, sum and control types.
`timescale 1ns / 1ps

module bb3_window (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shift,
    input  bb3_pkg::t_pix i_top,
    input  bb3_pkg::t_pix i_mid,
    input  bb3_pkg::t_pix i_bot,
    input  logic          i_adv,
    input  bb3_pkg::t_ctl i_ctl,
    output bb3_pkg::t_sums o_sum0,
    output bb3_pkg::t_sums o_sum1,
    output bb3_pkg::t_div  o_div0,
    output bb3_pkg::t_div  o_div1
);

    // Window is [column][row]; column 2 is newest, row 0 is the top.
    bb3_pkg::t_pix  r_win [3][3];
    bb3_pkg::t_sums w_colsum [3];
    bb3_pkg::t_sums w_sum0;
    bb3_pkg::t_sums w_sum1;
    bb3_pkg::t_div  w_div0;
    bb3_pkg::t_div  w_div1;
    bb3_pkg::t_sums r_sum0;
    bb3_pkg::t_sums r_sum1;
    bb3_pkg::t_div  r_div0;
    bb3_pkg::t_div  r_div1;

    // Shift in a new column from the line store and the incoming pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[c][r] <= '0;
                end
            end
        end else if (i_shift) begin
            r_win[0]    <= r_win[1];
            r_win[1]    <= r_win[2];
            r_win[2][0] <= i_top;
            r_win[2][1] <= i_mid;
            r_win[2][2] <= i_bot;
        end
    end

    // Column sums over the rows that lie inside the frame.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int ch = 0; ch < 3; ch++) begin
                w_colsum[c][ch] = bb3_pkg::SUM_W'(r_win[c][1][ch])
                    + (i_ctl.use_r0 ? bb3_pkg::SUM_W'(r_win[c][0][ch]) : '0)
                    + (i_ctl.use_r2 ? bb3_pkg::SUM_W'(r_win[c][2][ch]) : '0);
            end
        end
    end

    // Neighborhood sums: the column-1 result may take column 0, the column-2 one never.
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            w_sum1[ch] = w_colsum[1][ch] + w_colsum[2][ch];
            w_sum0[ch] = w_sum1[ch] + (i_ctl.use_c0 ? w_colsum[0][ch] : '0);
        end
    end

    // Divisor from the neighborhood shape: 2 or 3 columns by 2 or 3 rows.
    always_comb begin
        if (i_ctl.use_r0 && i_ctl.use_r2) begin
            w_div1 = bb3_pkg::DIV_6;
            w_div0 = i_ctl.use_c0 ? bb3_pkg::DIV_9 : bb3_pkg::DIV_6;
        end else begin
            w_div1 = bb3_pkg::DIV_4;
            w_div0 = i_ctl.use_c0 ? bb3_pkg::DIV_6 : bb3_pkg::DIV_4;
        end
    end

    // Sum stage register.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sum0 <= w_sum0;
            r_sum1 <= w_sum1;
            r_div0 <= w_div0;
            r_div1 <= w_div1;
        end
    end

    assign o_sum0 = r_sum0;
    assign o_sum1 = r_sum1;
    assign o_div0 = r_div0;
    assign o_div1 = r_div1;

endmodule

/* rtl/bb3_divide.sv */
// Rounded division of three channel sums by 4, 6 or 9 through a scaled reciprocal.
// Uses bb3_pkg for widths and the reciprocal and rounding tables.
`timescale 1ns / 1ps

module bb3_divide (
    input  logic           i_clk,
    input  logic           i_adv,
    input  bb3_pkg::t_sums i_sum,
    input  bb3_pkg::t_div  i_div,
    output bb3_pkg::t_pix  o_pix
);

    logic [bb3_pkg::PROD_W-1:0] r_prod [3];
    logic [bb3_pkg::RECIP_W-1:0] w_recip;
    bb3_pkg::t_x                 w_x [3];

    assign w_recip = bb3_pkg::recip(i_div);

    // Add half the divisor, then multiply by the reciprocal.
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            w_x[ch] = bb3_pkg::X_W'(i_sum[ch]) + bb3_pkg::X_W'(bb3_pkg::half(i_div));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_prod[ch] <= bb3_pkg::PROD_W'(w_x[ch]) * bb3_pkg::PROD_W'(w_recip);
            end
        end
    end

    // Quotient is the integer part of the scaled product.
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            o_pix[ch] = r_prod[ch][bb3_pkg::FRAC_W +: bb3_pkg::CH_W];
        end
    end

endmodule

/* rtl/bb3_out_queue.sv */
// Small result queue between the pipeline and the output stream.
// Uses bb3_pkg for the queue depth and the result word layout.
`timescale 1ns / 1ps

module bb3_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bb3_pkg::t_result i_data,
    output logic             o_room,
    output logic             o_valid,
    output bb3_pkg::t_result o_data,
    input  logic             i_pop
);

    bb3_pkg::t_result              r_mem [bb3_pkg::OQ_DEPTH];
    logic [bb3_pkg::OQ_PTR_W-1:0]  r_wr_ptr;
    logic [bb3_pkg::OQ_PTR_W-1:0]  r_rd_ptr;
    logic [bb3_pkg::OQ_CNT_W-1:0]  r_count;

    // Room is judged on the registered count alone, so the output ready never
    // reaches back into the pipeline in the same cycle.
    assign o_room  = (32'(r_count) < bb3_pkg::OQ_DEPTH);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/bb3_checker.sv */
// Port-level checks for the box blur top level, bound to every instance of it.
// Uses bb3_pkg for the register map; sees the top level's ports only.
`timescale 1ns / 1ps

module bb3_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [23:0]                m_axis_tdata,
    input logic                       m_axis_tlast,
    input logic                       m_axis_tuser,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [bb3_pkg::APB_AW-1:0] paddr,
    input logic [bb3_pkg::APB_DW-1:0] pwdata,
    input logic [bb3_pkg::APB_DW-1:0] prdata,
    input logic                       pready
);

    // The frame's last pixel always closes the run of its drain word.
    a_eof_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("end of frame without last in run");

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    // A width write reads back on the next cycle.
    a_width_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready
            && (paddr[bb3_pkg::APB_AW-1:2] == bb3_pkg::REG_FRAME_WIDTH) |=>
            (paddr[bb3_pkg::APB_AW-1:2] != bb3_pkg::REG_FRAME_WIDTH)
            || (prdata == bb3_pkg::APB_DW'($past(pwdata[bb3_pkg::FW_W-1:0]))))
        else $error("frame width readback mismatch");

    // Reset empties the result queue.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind box_blur_3x3_edge_aware_unit bb3_checker u_bb3_checker (.*);
